[hdl/midi_file_stream_parser_defines.svh]
// Assertion macros for the MIDI file stream parser checker.
// No dependencies.
`ifndef MIDI_FILE_STREAM_PARSER_DEFINES_SVH
`define MIDI_FILE_STREAM_PARSER_DEFINES_SVH
// Assert that a condition implies a consequence in the same cycle.
`define MFP_ASSERT_IMPL(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
	else $error("assertion failed");
// Assert that a condition implies a consequence in the next cycle.
`define MFP_ASSERT_NEXT(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
	else $error("assertion failed");
`endif

[hdl/mfsp_pkg.sv]
// Shared types and constants of the MIDI file stream parser.
// No dependencies.
package mfsp_pkg;
	localparam logic [3:0] K_HEADER  = 4'd0;
	localparam logic [3:0] K_TBEGIN  = 4'd1;
	localparam logic [3:0] K_CHAN    = 4'd2;
	localparam logic [3:0] K_META    = 4'd3;
	localparam logic [3:0] K_SYSEX   = 4'd4;
	localparam logic [3:0] K_PAYLOAD = 4'd5;
	localparam logic [3:0] K_TEND    = 4'd6;
	localparam logic [3:0] K_OK      = 4'd7;
	localparam logic [3:0] K_ERROR   = 4'd8;

	localparam int QUEUE_DEPTH = 4;

	typedef struct packed {
		logic [3:0]  kind;
		logic [31:0] delta_time;
		logic [3:0]  channel;
		logic [3:0]  status_kind;
		logic [7:0]  data_first;
		logic [7:0]  data_second;
		logic [31:0] length;
		logic [15:0] header_format;
		logic [15:0] header_tracks;
		logic [15:0] header_division;
		logic        last;
	} result_t;

	// header signature byte, index 0..3
	function automatic logic [7:0] hdr_sig(input logic [1:0] i);
		case (i)
			2'd0: hdr_sig = 8'h4D;
			2'd1: hdr_sig = 8'h54;
			2'd2: hdr_sig = 8'h68;
			default: hdr_sig = 8'h64;
		endcase
	endfunction

	function automatic logic [7:0] trk_sig(input logic [1:0] i);
		case (i)
			2'd0: trk_sig = 8'h4D;
			2'd1: trk_sig = 8'h54;
			2'd2: trk_sig = 8'h72;
			default: trk_sig = 8'h6B;
		endcase
	endfunction
endpackage

[hdl/mfsp_front.sv]
// Front part: byte parser state, produces up to two results per byte.
// Depends on mfsp_pkg.
module mfsp_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic [7:0]           data_byte,
	input  logic                 final_byte,
	output logic [1:0]           res_n,
	output mfsp_pkg::result_t    res0,
	output mfsp_pkg::result_t    res1
);
	typedef enum logic [3:0] {
		PH_HSIG, PH_HLEN, PH_HWORDS, PH_TSIG, PH_TLEN, PH_DELTA, PH_EVENT,
		PH_DATA1, PH_DATA2, PH_MTYPE, PH_MLEN, PH_SLEN, PH_PAYLOAD, PH_DONE,
		PH_ERROR
	} phase_t;

	phase_t      phase_q, phase_d;
	logic [3:0]  fc_q, fc_d;
	logic [31:0] acc_q, acc_d;
	logic [7:0]  rs_q, rs_d;
	logic [31:0] trk_q, trk_d;
	logic [31:0] pay_q, pay_d;
	logic [31:0] hd_q, hd_d;
	logic [7:0]  hb_q, hb_d;
	logic [15:0] hw_q, hw_d;

	// staging of results inside the step
	mfsp_pkg::result_t r0, r1;
	logic [1:0] n;

	always_comb begin
		logic        failed, done, in_track, ended, stok, stop;
		logic [31:0] vlq, tdec;
		logic [3:0]  hi;
		mfsp_pkg::result_t r;
		phase_d = phase_q; fc_d = fc_q; acc_d = acc_q; rs_d = rs_q;
		trk_d = trk_q; pay_d = pay_q; hd_d = hd_q; hb_d = hb_q;
		hw_d = hw_q;
		r0 = '0; r1 = '0; n = 2'd0; r = '0;
		failed = 1'b0; done = 1'b0; in_track = 1'b0; ended = 1'b0;
		stop = 1'b0;
		vlq = {acc_q[24:0], 7'd0} + {25'd0, data_byte[6:0]};
		tdec = trk_q - 32'd1;
		hi = rs_q[7:4];
		stok = (hi >= 4'd8) && (hi <= 4'd14);
		case (phase_q)
			PH_HSIG, PH_TSIG: begin
				if (data_byte != ((phase_q == PH_HSIG) ? mfsp_pkg::hdr_sig(fc_q[1:0])
						: mfsp_pkg::trk_sig(fc_q[1:0]))) begin
					failed = 1'b1;
				end else if (fc_q == 4'd3) begin
					fc_d = '0; acc_d = '0;
					phase_d = (phase_q == PH_HSIG) ? PH_HLEN : PH_TLEN;
				end else begin
					fc_d = fc_q + 4'd1;
				end
			end
			PH_HLEN, PH_TLEN: begin
				acc_d = {acc_q[23:0], data_byte};
				fc_d = fc_q + 4'd1;
				if (fc_q == 4'd3) begin
					fc_d = '0;
					if (phase_q == PH_HLEN) begin
						if (acc_d != 32'd6) failed = 1'b1;
						else begin acc_d = '0; phase_d = PH_HWORDS; end
					end else if (acc_d == 32'd0) begin
						failed = 1'b1;
					end else begin
						trk_d = acc_d;
						r0.kind = mfsp_pkg::K_TBEGIN; r0.length = acc_d; n = 2'd1;
						acc_d = '0; phase_d = PH_DELTA;
					end
				end
			end
			PH_HWORDS: begin
				if (fc_q < 4'd2) hw_d = {hw_q[7:0], data_byte};
				else acc_d = {acc_q[23:0], data_byte};
				fc_d = fc_q + 4'd1;
				if (fc_q == 4'd5) begin
					r0.kind = mfsp_pkg::K_HEADER; r0.header_format = hw_d;
					r0.header_tracks = acc_d[31:16]; r0.header_division = acc_d[15:0];
					n = 2'd1; fc_d = '0; acc_d = '0; phase_d = PH_TSIG;
				end
			end
			PH_DONE: failed = 1'b1;
			PH_ERROR: begin
				r0.kind = mfsp_pkg::K_ERROR; n = 2'd1; stop = 1'b1;
			end
			default: begin
				in_track = 1'b1;
				trk_d = tdec;
				r.kind = mfsp_pkg::K_CHAN; r.delta_time = hd_q;
				r.channel = rs_q[3:0]; r.status_kind = hi;
				case (phase_q)
					PH_DELTA: begin
						acc_d = vlq;
						if (!data_byte[7]) begin hd_d = vlq; phase_d = PH_EVENT; end
					end
					PH_EVENT: begin
						if (data_byte == 8'hFF) phase_d = PH_MTYPE;
						else if (data_byte == 8'hF0 || data_byte == 8'hF7) begin
							hb_d = data_byte; acc_d = '0; phase_d = PH_SLEN;
						end else if (data_byte[7]) begin
							rs_d = data_byte;
							if (data_byte[7:4] == 4'hF) failed = 1'b1;
							else phase_d = PH_DATA1;
						end else if (!stok) begin
							failed = 1'b1;
						end else if (hi == 4'hC || hi == 4'hD) begin
							r.data_first = data_byte; r0 = r; n = 2'd1; done = 1'b1;
						end else begin
							hb_d = data_byte; phase_d = PH_DATA2;
						end
					end
					PH_DATA1: begin
						if (hi == 4'hC || hi == 4'hD) begin
							r.data_first = data_byte; r0 = r; n = 2'd1; done = 1'b1;
						end else begin
							hb_d = data_byte; phase_d = PH_DATA2;
						end
					end
					PH_DATA2: begin
						r.data_first = hb_q; r.data_second = data_byte;
						r0 = r; n = 2'd1; done = 1'b1;
					end
					PH_MTYPE: begin
						hb_d = data_byte; acc_d = '0; phase_d = PH_MLEN;
					end
					PH_MLEN, PH_SLEN: begin
						acc_d = vlq;
						if (!data_byte[7]) begin
							r0 = '0;
							r0.kind = (phase_q == PH_MLEN) ? mfsp_pkg::K_META
								: mfsp_pkg::K_SYSEX;
							r0.delta_time = hd_q; r0.data_first = hb_q;
							r0.length = vlq; r0.last = (vlq == 32'd0);
							n = 2'd1; pay_d = vlq;
							if (vlq == 32'd0) done = 1'b1;
							else phase_d = PH_PAYLOAD;
						end
					end
					default: begin
						r0 = '0; r0.kind = mfsp_pkg::K_PAYLOAD;
						r0.data_first = data_byte; r0.last = (pay_q == 32'd1);
						n = 2'd1; pay_d = pay_q - 32'd1;
						if (pay_q == 32'd1) done = 1'b1;
					end
				endcase
			end
		endcase

		// track accounting
		if (!stop) begin
			if (in_track && !failed) begin
				if (done) begin
					acc_d = '0;
					if (tdec == 32'd0) begin
						if (n == 2'd0) begin
							r0 = '0; r0.kind = mfsp_pkg::K_TEND; n = 2'd1;
						end else begin
							r1 = '0; r1.kind = mfsp_pkg::K_TEND; n = 2'd2;
						end
						ended = 1'b1; fc_d = '0; phase_d = PH_TSIG;
					end else begin
						phase_d = PH_DELTA;
					end
				end else if (tdec == 32'd0) begin
					failed = 1'b1;
				end
			end
			// end of file
			if (!failed && final_byte) begin
				if (phase_d == PH_TSIG && fc_d == 4'd0) begin
					if (ended) n = n - 2'd1;
					if (n == 2'd0) begin
						r0 = '0; r0.kind = mfsp_pkg::K_OK; n = 2'd1;
					end else begin
						r1 = '0; r1.kind = mfsp_pkg::K_OK; n = 2'd2;
					end
					phase_d = PH_DONE;
				end else begin
					failed = 1'b1;
				end
			end
			if (failed) begin
				phase_d = PH_ERROR;
				if (n == 2'd0) begin
					r0 = '0; r0.kind = mfsp_pkg::K_ERROR; n = 2'd1;
				end else begin
					r1 = '0; r1.kind = mfsp_pkg::K_ERROR; n = 2'd2;
				end
			end
		end
	end

	assign res_n = in_valid ? n : 2'd0;
	assign res0 = r0;
	assign res1 = r1;

	// parser state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HSIG; fc_q <= '0; acc_q <= '0; rs_q <= 8'hFF;
			trk_q <= '0; pay_q <= '0; hd_q <= '0; hb_q <= '0;
			hw_q <= '0;
		end else if (in_valid) begin
			phase_q <= phase_d; fc_q <= fc_d; acc_q <= acc_d; rs_q <= rs_d;
			trk_q <= trk_d; pay_q <= pay_d; hd_q <= hd_d; hb_q <= hb_d;
			hw_q <= hw_d;
		end
	end
endmodule

[hdl/mfsp_queue.sv]
// Result queue between parser and output side; two writes, one read a cycle.
// Depends on mfsp_pkg.
module mfsp_queue #(
	parameter int DEPTH = mfsp_pkg::QUEUE_DEPTH
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [1:0]        wr_n,
	input  mfsp_pkg::result_t wr0,
	input  mfsp_pkg::result_t wr1,
	input  logic              rd,
	output mfsp_pkg::result_t rd_data,
	output logic              empty,
	output logic              room2
);
	localparam int AW = $clog2(DEPTH);
	mfsp_pkg::result_t mem_q [DEPTH];
	logic [AW-1:0] wp_q, rp_q;
	logic [AW:0]   cnt_q;
	logic          do_rd;

	assign empty = (cnt_q == '0);
	assign do_rd = rd && !empty;
	assign room2 = (cnt_q <= (AW+1)'(DEPTH - 2));
	assign rd_data = mem_q[rp_q];

	// storage writes
	always_ff @(posedge clk) begin
		if (wr_n != 2'd0) mem_q[wp_q] <= wr0;
		if (wr_n == 2'd2) mem_q[wp_q + AW'(1)] <= wr1;
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0; rp_q <= '0; cnt_q <= '0;
		end else begin
			wp_q <= wp_q + AW'(wr_n);
			if (do_rd) rp_q <= rp_q + AW'(1);
			cnt_q <= cnt_q + (AW+1)'(wr_n) - (AW+1)'(do_rd);
		end
	end
endmodule

[hdl/midi_file_stream_parser.sv]
// Top level of the MIDI file stream parser.
// Depends on mfsp_pkg, mfsp_front, mfsp_queue.
// Takes one file byte per cycle when full is low; each byte is parsed in the
// cycle it is accepted and yields zero, one or two results, which enter a
// small result queue and leave one per cycle on pop. Input stalls only while
// the queue lacks room for two results, so with pop held high throughput is
// one byte per cycle unless bytes yielding two results fill up the queue.
module midi_file_stream_parser #(
	parameter int DEPTH = mfsp_pkg::QUEUE_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [7:0]  data_byte,
	input  logic        final_byte,
	output logic        empty,
	input  logic        pop,
	output logic [3:0]  kind,
	output logic [31:0] delta_time,
	output logic [3:0]  channel,
	output logic [3:0]  status_kind,
	output logic [7:0]  data_first,
	output logic [7:0]  data_second,
	output logic [31:0] length,
	output logic [15:0] header_format,
	output logic [15:0] header_tracks,
	output logic [15:0] header_division,
	output logic        last
);
	logic [1:0] res_n;
	mfsp_pkg::result_t res0, res1, head;
	logic room2;

	assign full = !room2;

	mfsp_front u_front (
		.clk(clk), .arst_n(arst_n), .in_valid(push && room2),
		.data_byte(data_byte), .final_byte(final_byte),
		.res_n(res_n), .res0(res0), .res1(res1)
	);

	mfsp_queue #(.DEPTH(DEPTH)) u_queue (
		.clk(clk), .arst_n(arst_n), .wr_n(res_n), .wr0(res0), .wr1(res1),
		.rd(pop), .rd_data(head), .empty(empty), .room2(room2)
	);

	assign kind = head.kind;
	assign delta_time = head.delta_time;
	assign channel = head.channel;
	assign status_kind = head.status_kind;
	assign data_first = head.data_first;
	assign data_second = head.data_second;
	assign length = head.length;
	assign header_format = head.header_format;
	assign header_tracks = head.header_tracks;
	assign header_division = head.header_division;
	assign last = head.last;
endmodule

[hdl/mfsp_checker.sv]
// Port-level checker for the MIDI file stream parser, bound to the top level.
// Depends on midi_file_stream_parser_defines.svh and mfsp_pkg.
`include "midi_file_stream_parser_defines.svh"
module mfsp_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       push,
	input logic       full,
	input logic       empty,
	input logic       pop,
	input logic [3:0] kind,
	input logic       last
);
	// a waiting result holds while not taken
	`MFP_ASSERT_NEXT(a_hold, clk, arst_n, !empty && !pop, !empty && $stable(kind))
	// kind stays within the defined codes
	`MFP_ASSERT_IMPL(a_kind, clk, arst_n, !empty, kind <= mfsp_pkg::K_ERROR)
	// last only on payload, meta or sysex results
	`MFP_ASSERT_IMPL(a_last, clk, arst_n, !empty && last,
		kind == mfsp_pkg::K_META || kind == mfsp_pkg::K_SYSEX || kind == mfsp_pkg::K_PAYLOAD)
	// with nothing queued the input side has room
	`MFP_ASSERT_IMPL(a_room, clk, arst_n, empty, !full)
endmodule

bind midi_file_stream_parser mfsp_checker u_checker (
	.clk(clk), .arst_n(arst_n), .push(push), .full(full), .empty(empty),
	.pop(pop), .kind(kind), .last(last)
);

[sim/midi_file_stream_parser_test.sv]
// Self-checking testbench for the MIDI file stream parser.
// Depends on mfsp_pkg and midi_file_stream_parser; builds a random file, predicts its results.
`timescale 1ns / 1ps

module midi_file_stream_parser_test;
	typedef enum logic [4:0] {
		PH_HSIG, PH_HLEN, PH_HWORDS, PH_TSIG, PH_TLEN, PH_DELTA, PH_EVENT,
		PH_DATA1, PH_DATA2, PH_MTYPE, PH_MLEN, PH_SLEN, PH_PAYLOAD, PH_DONE,
		PH_ERROR
	} parse_phase_t;

	typedef struct {
		logic [7:0] data;
		logic       fin;
	} file_byte_t;

	localparam logic [31:0] HDR_SIG  = 32'h4D546864;
	localparam logic [31:0] TRK_SIG  = 32'h4D54726B;
	localparam logic [7:0]  META_LEAD = 8'hFF;
	localparam logic [7:0]  SYSEX_F0 = 8'hF0;
	localparam logic [7:0]  SYSEX_F7 = 8'hF7;
	localparam logic [7:0]  NO_STATUS = 8'hFF;
	localparam logic [3:0]  NIB_PROGRAM = 4'hC;
	localparam logic [3:0]  NIB_PRESSURE = 4'hD;
	localparam int          STALL_LIMIT = 5000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        push = 1'b0;
	logic        full;
	logic [7:0]  data_byte = 8'd0;
	logic        final_byte = 1'b0;
	logic        empty;
	logic        pop = 1'b0;
	logic [3:0]  kind;
	logic [31:0] delta_time;
	logic [3:0]  channel;
	logic [3:0]  status_kind;
	logic [7:0]  data_first;
	logic [7:0]  data_second;
	logic [31:0] length;
	logic [15:0] header_format;
	logic [15:0] header_tracks;
	logic [15:0] header_division;
	logic        last;

	midi_file_stream_parser u_dut (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full),
		.data_byte(data_byte), .final_byte(final_byte), .empty(empty), .pop(pop),
		.kind(kind), .delta_time(delta_time), .channel(channel),
		.status_kind(status_kind), .data_first(data_first), .data_second(data_second),
		.length(length), .header_format(header_format), .header_tracks(header_tracks),
		.header_division(header_division), .last(last)
	);

	always #5 clk = ~clk;

	file_byte_t          file_q[$];
	mfsp_pkg::result_t   expected_q[$];
	int                  mismatches = 0;

	// Parser state mirror
	parse_phase_t ph = PH_HSIG;
	int           fc = 0;
	logic [31:0]  acc = '0;
	logic [7:0]   run_stat = NO_STATUS;
	logic [31:0]  track_left = '0;
	logic [31:0]  payload_left = '0;
	logic [31:0]  held_delta = '0;
	logic [7:0]   held_byte = '0;
	logic [15:0]  hdr_word = '0;
	mfsp_pkg::result_t rows[2];
	int           nrows;

	// Open a result slot; a third result overwrites the second.
	function automatic int add_row(input logic [3:0] k);
		int i;
		i = nrows;
		if (i >= 2) i = 1;
		else nrows++;
		rows[i] = '0;
		rows[i].kind = k;
		return i;
	endfunction

	function automatic void chan_row(input logic [7:0] d1, input logic [7:0] d2);
		int i;
		i = add_row(mfsp_pkg::K_CHAN);
		rows[i].delta_time = held_delta;
		rows[i].channel = run_stat[3:0];
		rows[i].status_kind = run_stat[7:4];
		rows[i].data_first = d1;
		rows[i].data_second = d2;
	endfunction

	function automatic logic status_valid();
		return run_stat[7:4] >= 4'h8 && run_stat[7:4] <= 4'hE;
	endfunction

	// First data byte; one-byte messages complete here
	function automatic logic take_first(input logic [7:0] b);
		if (run_stat[7:4] == NIB_PROGRAM || run_stat[7:4] == NIB_PRESSURE) begin
			chan_row(b, 8'd0);
			return 1'b1;
		end
		held_byte = b;
		ph = PH_DATA2;
		return 1'b0;
	endfunction

	// Advance the mirror by one byte and queue the results it causes
	function automatic void predict_byte(input logic [7:0] b, input logic fin);
		logic        failed, done, in_track, ended;
		logic [31:0] vlq, sig;
		int          i;
		failed = 0; done = 0; in_track = 0; ended = 0;
		nrows = 0;
		vlq = (acc << 7) + {25'd0, b[6:0]};
		if (ph == PH_ERROR) begin
			i = add_row(mfsp_pkg::K_ERROR);
		end else begin
			case (ph)
				PH_HSIG, PH_TSIG: begin
					sig = (ph == PH_HSIG) ? HDR_SIG : TRK_SIG;
					if (b != sig[8 * (3 - (fc & 3)) +: 8]) begin
						failed = 1;
					end else begin
						fc++;
						if (fc >= 4) begin
							fc = 0;
							acc = 0;
							ph = (ph == PH_HSIG) ? PH_HLEN : PH_TLEN;
						end
					end
				end
				PH_HLEN, PH_TLEN: begin
					acc = (acc << 8) | {24'd0, b};
					fc++;
					if (fc >= 4) begin
						fc = 0;
						if (ph == PH_HLEN) begin
							if (acc != 6) failed = 1;
							else begin
								acc = 0;
								ph = PH_HWORDS;
							end
						end else if (acc == 0) begin
							failed = 1;
						end else begin
							track_left = acc;
							i = add_row(mfsp_pkg::K_TBEGIN);
							rows[i].length = acc;
							acc = 0;
							ph = PH_DELTA;
						end
					end
				end
				PH_HWORDS: begin
					if (fc < 2) hdr_word = {hdr_word[7:0], b};
					else acc = (acc << 8) | {24'd0, b};
					fc++;
					if (fc >= 6) begin
						i = add_row(mfsp_pkg::K_HEADER);
						rows[i].header_format = hdr_word;
						rows[i].header_tracks = acc[31:16];
						rows[i].header_division = acc[15:0];
						fc = 0;
						acc = 0;
						ph = PH_TSIG;
					end
				end
				PH_DONE: failed = 1;
				default: begin
					in_track = 1;
					track_left--;
					case (ph)
						PH_DELTA: begin
							acc = vlq;
							if (!b[7]) begin
								held_delta = vlq;
								ph = PH_EVENT;
							end
						end
						PH_EVENT: begin
							if (b == META_LEAD) begin
								ph = PH_MTYPE;
							end else if (b == SYSEX_F0 || b == SYSEX_F7) begin
								held_byte = b;
								acc = 0;
								ph = PH_SLEN;
							end else if (b[7]) begin
								run_stat = b;
								if (!status_valid()) failed = 1;
								else ph = PH_DATA1;
							end else if (!status_valid()) begin
								failed = 1;
							end else begin
								done = take_first(b);
							end
						end
						PH_DATA1: done = take_first(b);
						PH_DATA2: begin
							chan_row(held_byte, b);
							done = 1;
						end
						PH_MTYPE: begin
							held_byte = b;
							acc = 0;
							ph = PH_MLEN;
						end
						PH_MLEN, PH_SLEN: begin
							acc = vlq;
							if (!b[7]) begin
								i = add_row(ph == PH_MLEN ? mfsp_pkg::K_META
									: mfsp_pkg::K_SYSEX);
								rows[i].delta_time = held_delta;
								rows[i].data_first = held_byte;
								rows[i].length = vlq;
								rows[i].last = (vlq == 0);
								payload_left = vlq;
								if (vlq == 0) done = 1;
								else ph = PH_PAYLOAD;
							end
						end
						default: begin
							i = add_row(mfsp_pkg::K_PAYLOAD);
							rows[i].data_first = b;
							rows[i].last = (payload_left == 1);
							payload_left--;
							if (payload_left == 0) done = 1;
						end
					endcase
				end
			endcase

			// Event completion and track closing
			if (in_track && !failed) begin
				if (done) begin
					acc = 0;
					if (track_left == 0) begin
						i = add_row(mfsp_pkg::K_TEND);
						ended = 1;
						fc = 0;
						ph = PH_TSIG;
					end else begin
						ph = PH_DELTA;
					end
				end else if (track_left == 0) begin
					failed = 1;
				end
			end

			// End of file check; file ok replaces a same-byte track end
			if (!failed && fin) begin
				if (ph == PH_TSIG && fc == 0) begin
					if (ended) nrows--;
					i = add_row(mfsp_pkg::K_OK);
					ph = PH_DONE;
				end else begin
					failed = 1;
				end
			end

			if (failed) begin
				ph = PH_ERROR;
				i = add_row(mfsp_pkg::K_ERROR);
			end
		end
		for (int j = 0; j < nrows; j++) expected_q.push_back(rows[j]);
	endfunction

	// File construction
	logic [7:0] body[$];
	logic [7:0] gen_status = NO_STATUS;

	task automatic put_file(input logic [7:0] b, input logic fin);
		file_byte_t fb;
		fb.data = b;
		fb.fin = fin;
		file_q.push_back(fb);
	endtask

	task automatic put_word32(input logic [31:0] w);
		for (int s = 3; s >= 0; s--) put_file(w[8 * s +: 8], 1'b0);
	endtask

	// Delta with random content, mostly one byte, sometimes long enough to wrap
	task automatic put_delta();
		int r, k;
		logic [7:0] v;
		r = $urandom_range(0, 99);
		k = (r < 60) ? 1 : (r < 90) ? $urandom_range(2, 4) : $urandom_range(5, 7);
		for (int j = 0; j < k; j++) begin
			v = 8'($urandom);
			body.push_back(j < k - 1 ? (v | 8'h80) : (v & 8'h7F));
		end
	endtask

	// Length quantity, occasionally padded with leading zero groups
	task automatic put_len(input int v);
		int pad;
		pad = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 3) : 0;
		repeat (pad) body.push_back(8'h80);
		if (v >= 128) body.push_back(8'(8'h80 | ((v >> 7) & 8'h7F)));
		body.push_back(8'(v & 8'h7F));
	endtask

	task automatic put_chan();
		logic [3:0] nib;
		logic       explicit_st;
		nib = 4'($urandom_range(8, 14));
		explicit_st = (gen_status == NO_STATUS) || ($urandom_range(0, 1) == 1);
		if (explicit_st) begin
			gen_status = {nib, 4'($urandom)};
			body.push_back(gen_status);
			body.push_back(8'($urandom_range(0, 255)));
		end else begin
			body.push_back(8'($urandom_range(0, 127)));
		end
		if (gen_status[7:4] != NIB_PROGRAM && gen_status[7:4] != NIB_PRESSURE)
			body.push_back(8'($urandom_range(0, 255)));
	endtask

	task automatic put_blob(input logic [7:0] lead);
		int r, n;
		body.push_back(lead);
		if (lead == META_LEAD) body.push_back(8'($urandom_range(0, 255)));
		r = $urandom_range(0, 99);
		n = (r < 30) ? 0 : (r < 96) ? $urandom_range(1, 6) : $urandom_range(128, 140);
		put_len(n);
		repeat (n) body.push_back(8'($urandom_range(0, 255)));
	endtask

	task automatic put_event();
		int r;
		put_delta();
		r = $urandom_range(0, 99);
		if (r < 60) put_chan();
		else if (r < 80) put_blob(META_LEAD);
		else put_blob($urandom_range(0, 1) ? SYSEX_F0 : SYSEX_F7);
	endtask

	// Wrap the body in a track chunk; shrink under-states its length
	task automatic emit_track(input int shrink);
		put_word32(TRK_SIG);
		put_word32(body.size() - shrink);
		foreach (body[j]) put_file(body[j], 1'b0);
		body.delete();
	endtask

	task automatic build_file();
		int mode;
		logic [7:0] bad;
		put_word32(HDR_SIG);
		put_word32(32'd6);
		for (int j = 0; j < 6; j++) put_file(8'($urandom_range(0, 255)), 1'b0);

		// Directed track: every channel message with extreme data, long deltas,
		// empty meta, both sysex leads, running status after an explicit one
		for (int nib = 8; nib <= 14; nib++) begin
			body.push_back(8'h00);
			gen_status = {4'(nib), 4'(nib * 3)};
			body.push_back(gen_status);
			body.push_back(nib[0] ? 8'hFF : 8'h00);
			if (nib != NIB_PROGRAM && nib != NIB_PRESSURE)
				body.push_back(nib[0] ? 8'h00 : 8'hFF);
		end
		body.push_back(8'h8F); body.push_back(8'hFF); body.push_back(8'hFF);
		body.push_back(8'hFF); body.push_back(8'h7F);
		body.push_back(8'h7F); body.push_back(8'hFF);
		repeat (6) body.push_back(8'hFF);
		body.push_back(8'h01);
		body.push_back(8'h00); body.push_back(8'h40);
		body.push_back(8'h00); body.push_back(META_LEAD);
		body.push_back(8'h2F); body.push_back(8'h00);
		body.push_back(8'h00); body.push_back(SYSEX_F0);
		body.push_back(8'h02); body.push_back(8'h7E); body.push_back(8'hF7);
		body.push_back(8'h00); body.push_back(SYSEX_F7); body.push_back(8'h00);
		emit_track(0);

		// Random well-formed tracks
		while (file_q.size() < 620) begin
			repeat ($urandom_range(1, 8)) put_event();
			emit_track(0);
		end

		// Ending: clean close or one of the error paths, then stuck bytes
		mode = $urandom_range(0, 5);
		case (mode)
			0: file_q[file_q.size() - 1].fin = 1'b1;
			1: begin
				put_word32(TRK_SIG);
				put_word32(32'd0);
			end
			2: begin
				bad = $urandom_range(0, 1) ? 8'($urandom_range(8'hF1, 8'hF6))
					: 8'($urandom_range(8'hF8, 8'hFE));
				body.push_back(8'h00);
				body.push_back(bad);
				body.push_back(8'h00);
				emit_track(0);
			end
			3: begin
				put_file(TRK_SIG[31:24], 1'b0);
				put_file(TRK_SIG[23:16], 1'b1);
			end
			4: begin
				put_delta();
				put_chan();
				emit_track(1);
			end
			default: put_word32(TRK_SIG ^ 32'h1);
		endcase
		repeat ($urandom_range(2, 4))
			put_file(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
	endtask

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50) return 0;
		if (r < 85) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	// Byte driver
	int byte_gap = 0;
	int bytes_sent = 0;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			push <= 1'b0;
			data_byte <= 8'd0;
			final_byte <= 1'b0;
		end else begin
			if (push && !full) begin
				predict_byte(data_byte, final_byte);
				void'(file_q.pop_front());
				bytes_sent++;
				// every fourth stretch of 32 bytes goes back to back
				byte_gap = ((bytes_sent / 32) % 4 == 0) ? 0 : pick_gap();
			end
			if (!push || !full) begin
				if (byte_gap > 0 || file_q.size() == 0) begin
					if (byte_gap > 0) byte_gap--;
					push <= 1'b0;
				end else begin
					push <= 1'b1;
					data_byte <= file_q[0].data;
					final_byte <= file_q[0].fin;
				end
			end
		end
	end

	// Result monitor with random stalls
	int                pop_stall = 0;
	mfsp_pkg::result_t got;
	mfsp_pkg::result_t want;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pop <= 1'b0;
		end else begin
			if (pop && !empty) begin
				got = '{kind, delta_time, channel, status_kind, data_first, data_second,
					length, header_format, header_tracks, header_division, last};
				if (expected_q.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result: kind=%0d len=%0d d1=%0h",
							got.kind, got.length, got.data_first);
				end else begin
					want = expected_q.pop_front();
					if (got !== want) begin
						mismatches++;
						if (mismatches <= 10) begin
							$display("result mismatch, expected vs actual:");
							$display("  kind %0d/%0d delta %0h/%0h chan %0h/%0h skind %0h/%0h",
								want.kind, got.kind, want.delta_time, got.delta_time,
								want.channel, got.channel, want.status_kind, got.status_kind);
							$display("  d1 %0h/%0h d2 %0h/%0h len %0h/%0h last %0b/%0b",
								want.data_first, got.data_first, want.data_second,
								got.data_second, want.length, got.length, want.last, got.last);
							$display("  fmt %0h/%0h trk %0h/%0h div %0h/%0h",
								want.header_format, got.header_format, want.header_tracks,
								got.header_tracks, want.header_division, got.header_division);
						end
					end
				end
			end
			if (pop_stall > 0) begin
				pop_stall--;
				pop <= 1'b0;
			end else begin
				pop <= 1'b1;
				if ($urandom_range(0, 99) < 15) pop_stall = pick_gap();
			end
		end
	end

	// Watchdog on cycles without any transfer while work remains
	int idle_cycles = 0;
	always @(posedge clk) begin
		if ((push && !full) || (pop && !empty)
				|| (file_q.size() == 0 && expected_q.size() == 0)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= STALL_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		build_file();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		wait (file_q.size() == 0);
		while (expected_q.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (mismatches == 0 && expected_q.size() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end
endmodule

[files.f]
+incdir+hdl
hdl/mfsp_pkg.sv
hdl/mfsp_front.sv
hdl/mfsp_queue.sv
hdl/midi_file_stream_parser.sv
hdl/mfsp_checker.sv
sim/midi_file_stream_parser_test.sv
